// File: hdl/vc64_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the 64-bit varint codec.
// No dependencies; used by the interfaces and imported by all codec modules.
package vc64_pkg;

    localparam int unsigned VALUE_W = 64;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned GROUP_W = 7;
    localparam int unsigned COUNT_W = 4;
    localparam int unsigned SHIFT_W = 6;

    localparam logic [BYTE_W-1:0]  CONT_BIT     = 8'h80;
    localparam logic [BYTE_W-1:0]  PAYLOAD_MASK = 8'h7F;
    localparam logic [COUNT_W-1:0] MAX_BYTES    = 4'd10;

    typedef enum logic
    {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } op_t;

    // Decoder status for the byte currently presented.
    typedef struct packed
    {
        logic                emit;
        logic [COUNT_W-1:0]  count;
        logic [VALUE_W-1:0]  value;
    } dec_res_t;

endpackage

// File: hdl/vc64_in_if.sv
`timescale 1ns / 1ps
// Input channel of the varint codec: valid/ready plus one work item.
// Depends on vc64_pkg.
interface vc64_in_if;
    logic                          valid;
    logic                          ready;
    vc64_pkg::op_t                 operation;
    logic [vc64_pkg::VALUE_W-1:0]  value_in;
    logic [vc64_pkg::BYTE_W-1:0]   byte_in;

    modport source (output valid, operation, value_in, byte_in, input ready);
    modport sink   (input valid, operation, value_in, byte_in, output ready);
endinterface

// File: hdl/vc64_out_if.sv
`timescale 1ns / 1ps
// Output channel of the varint codec: valid/ready plus one result.
// Depends on vc64_pkg.
interface vc64_out_if;
    logic                          valid;
    logic                          ready;
    logic [vc64_pkg::BYTE_W-1:0]   byte_out;
    logic [vc64_pkg::VALUE_W-1:0]  value_out;
    logic [vc64_pkg::COUNT_W-1:0]  byte_count;
    logic                          last;

    modport source (output valid, byte_out, value_out, byte_count, last, input ready);
    modport sink   (input valid, byte_out, value_out, byte_count, last, output ready);
endinterface

// File: hdl/vc64_dec.sv
`timescale 1ns / 1ps
// Varint decoder state: accumulator and byte index, one byte per step.
// Depends on vc64_pkg.
module vc64_dec
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [vc64_pkg::BYTE_W-1:0]   byte_in,
    output vc64_pkg::dec_res_t            res
);
    import vc64_pkg::*;

    logic [VALUE_W-1:0] acc_reg;
    logic [VALUE_W-1:0] acc_next;
    logic [COUNT_W-1:0] idx_reg;
    logic [COUNT_W-1:0] idx_next;
    logic [SHIFT_W-1:0] shamt;
    logic [VALUE_W-1:0] acc_or;
    logic               last_byte;

    // 7 * idx, at most 63; bits shifted past 63 drop out
    assign shamt     = SHIFT_W'({idx_reg, 3'b000} - {3'b000, idx_reg});
    assign acc_or    = acc_reg | (VALUE_W'(byte_in & PAYLOAD_MASK) << shamt);
    assign last_byte = (idx_reg == MAX_BYTES - 4'd1);

    always_comb
    begin
        res.emit  = ((byte_in & CONT_BIT) == '0) || last_byte;
        res.count = idx_reg + 4'd1;
        res.value = acc_or;
        acc_next  = acc_reg;
        idx_next  = idx_reg;
        if (step)
        begin
            if (res.emit)
            begin
                acc_next = '0;
                idx_next = '0;
            end
            else
            begin
                acc_next = acc_or;
                idx_next = idx_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            idx_reg <= idx_next;
        end
    end

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg < MAX_BYTES)
        else $error("decoder index out of range");

    a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.emit |=> idx_reg == '0 && acc_reg == '0)
        else $error("decoder state not cleared after emit");

    a_index_advance: assert property (@(posedge clk) disable iff (!rst_n)
        step && !res.emit |=> idx_reg == $past(idx_reg) + 4'd1)
        else $error("decoder index did not advance");

endmodule

// File: hdl/varint_codec_64.sv
`timescale 1ns / 1ps
// An accepted item is registered in the work register, each of its results in the
// output register; the work register holds while the output register is stalled.
// Throughput: up to one result per cycle while dout.ready is high; an encode item holds
// the work register one step per output byte, a decode byte a single step.
// Reset (rst_n, async, active low) empties both registers and clears the decoder.
// Top level of the varint codec. Depends on vc64_pkg, vc64_in_if, vc64_out_if, vc64_dec.
module varint_codec_64
(
    input  logic       clk,
    input  logic       rst_n,
    vc64_in_if.sink    din,
    vc64_out_if.source dout
);
    import vc64_pkg::*;

    // work register: item being turned into results
    logic               work_valid_reg;
    logic               work_valid_next;
    op_t                work_op_reg;
    op_t                work_op_next;
    logic [VALUE_W-1:0] work_val_reg;
    logic [VALUE_W-1:0] work_val_next;
    logic [BYTE_W-1:0]  work_byte_reg;
    logic [BYTE_W-1:0]  work_byte_next;
    logic [COUNT_W-1:0] work_cnt_reg;
    logic [COUNT_W-1:0] work_cnt_next;

    // output register
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [BYTE_W-1:0]  out_byte_reg;
    logic [BYTE_W-1:0]  out_byte_next;
    logic [VALUE_W-1:0] out_value_reg;
    logic [VALUE_W-1:0] out_value_next;
    logic [COUNT_W-1:0] out_cnt_reg;
    logic [COUNT_W-1:0] out_cnt_next;
    logic               out_last_reg;
    logic               out_last_next;

    logic               out_free;
    logic               advance;
    logic               is_dec;
    logic               enc_last;
    logic               finish;
    logic               load_out;
    logic               accept;
    dec_res_t           dec_res;

    vc64_dec u_dec
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance && is_dec),
        .byte_in (work_byte_reg),
        .res     (dec_res)
    );

    assign out_free = !out_valid_reg || dout.ready;
    assign advance  = work_valid_reg && out_free;
    assign is_dec   = (work_op_reg == OP_DECODE);
    assign enc_last = (work_val_reg[VALUE_W-1:GROUP_W] == '0);
    assign finish   = advance && (is_dec || enc_last);
    assign load_out = advance && (!is_dec || dec_res.emit);
    assign din.ready = !work_valid_reg || finish;
    assign accept   = din.valid && din.ready;

    always_comb
    begin
        work_valid_next = work_valid_reg;
        work_op_next    = work_op_reg;
        work_val_next   = work_val_reg;
        work_byte_next  = work_byte_reg;
        work_cnt_next   = work_cnt_reg;
        if (accept)
        begin
            work_valid_next = 1'b1;
            work_op_next    = din.operation;
            work_val_next   = din.value_in;
            work_byte_next  = din.byte_in;
            work_cnt_next   = '0;
        end
        else if (finish)
        begin
            work_valid_next = 1'b0;
        end
        else if (advance)
        begin
            // encode with more groups to go
            work_val_next = work_val_reg >> GROUP_W;
            work_cnt_next = work_cnt_reg + 4'd1;
        end

        out_valid_next = out_valid_reg && !dout.ready;
        out_byte_next  = out_byte_reg;
        out_value_next = out_value_reg;
        out_cnt_next   = out_cnt_reg;
        out_last_next  = out_last_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            if (is_dec)
            begin
                out_byte_next  = '0;
                out_value_next = dec_res.value;
                out_cnt_next   = dec_res.count;
                out_last_next  = 1'b1;
            end
            else
            begin
                out_byte_next  = (work_val_reg[BYTE_W-1:0] & PAYLOAD_MASK)
                               | (enc_last ? '0 : CONT_BIT);
                out_value_next = '0;
                out_cnt_next   = work_cnt_reg + 4'd1;
                out_last_next  = enc_last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            work_valid_reg <= work_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_op_reg   <= work_op_next;
        work_val_reg  <= work_val_next;
        work_byte_reg <= work_byte_next;
        work_cnt_reg  <= work_cnt_next;
        out_byte_reg  <= out_byte_next;
        out_value_reg <= out_value_next;
        out_cnt_reg   <= out_cnt_next;
        out_last_reg  <= out_last_next;
    end

    assign dout.valid      = out_valid_reg;
    assign dout.byte_out   = out_byte_reg;
    assign dout.value_out  = out_value_reg;
    assign dout.byte_count = out_cnt_reg;
    assign dout.last       = out_last_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_cnt_reg != '0 && out_cnt_reg <= MAX_BYTES)
        else $error("byte count out of range");

    a_cont_on_middle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_last_reg |-> out_byte_reg[BYTE_W-1])
        else $error("non-final encode byte lacks continuation bit");

    a_stall_holds_work: assert property (@(posedge clk) disable iff (!rst_n)
        work_valid_reg && !out_free |=> work_valid_reg && $stable(work_val_reg)
            && $stable(work_cnt_reg))
        else $error("work item changed while output stalled");

    a_enc_chain: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && !is_dec && !enc_last |=> work_valid_reg && !is_dec
            && work_cnt_reg == $past(work_cnt_reg) + 4'd1)
        else $error("encode item dropped before its last byte");

endmodule

// File: tb/tb_varint_codec_64.sv
`timescale 1ns / 1ps
// Self-checking bench for varint_codec_64: directed and random encode/decode transfers,
// checked against an in-bench mirror of the LEB128 codec. Depends on vc64_pkg, vc64_in_if,
// vc64_out_if and the codec RTL.
module tb_varint_codec_64;
    import vc64_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed
    {
        logic [BYTE_W-1:0]  enc_byte;
        logic [VALUE_W-1:0] dec_value;
        logic [COUNT_W-1:0] count;
        logic               is_last;
    } codec_out_t;

    // Mirror of the codec: decoder accumulator plus the queue of results still due.
    class leb_mirror;
        codec_out_t         due[$];
        logic [VALUE_W-1:0] acc;
        logic [COUNT_W-1:0] idx;
        int                 errors;

        function new();
            acc    = '0;
            idx    = '0;
            errors = 0;
        endfunction

        function void note_item(op_t op, logic [VALUE_W-1:0] v, logic [BYTE_W-1:0] b);
            codec_out_t         r;
            logic [VALUE_W-1:0] rest;
            logic [COUNT_W-1:0] n;
            int                 shift;
            if (op == OP_ENCODE)
            begin
                rest = v;
                n    = 4'd1;
                while (rest >= VALUE_W'(CONT_BIT))
                begin
                    r.enc_byte  = (rest[BYTE_W-1:0] & PAYLOAD_MASK) | CONT_BIT;
                    r.dec_value = '0;
                    r.count     = n;
                    r.is_last   = 1'b0;
                    due.push_back(r);
                    rest = rest >> GROUP_W;
                    n++;
                end
                r.enc_byte  = rest[BYTE_W-1:0] & PAYLOAD_MASK;
                r.dec_value = '0;
                r.count     = n;
                r.is_last   = 1'b1;
                due.push_back(r);
            end
            else
            begin
                if (idx >= MAX_BYTES)
                begin
                    idx = '0;
                    acc = '0;
                end
                shift = GROUP_W * int'(idx);
                // on the tenth byte only payload bit 0 lands at bit 63
                if (shift <= VALUE_W - 1)
                    acc |= {56'd0, b & PAYLOAD_MASK} << shift;
                if (!b[BYTE_W-1] || int'(idx) + 1 >= int'(MAX_BYTES))
                begin
                    r.enc_byte  = '0;
                    r.dec_value = acc;
                    r.count     = idx + 4'd1;
                    r.is_last   = 1'b1;
                    due.push_back(r);
                    acc = '0;
                    idx = '0;
                end
                else
                    idx = idx + 4'd1;
            end
        endfunction

        function void check_output(logic [BYTE_W-1:0] b, logic [VALUE_W-1:0] v,
                                   logic [COUNT_W-1:0] cnt, logic lst);
            codec_out_t r;
            if (due.size() == 0)
            begin
                $error("unexpected result: byte_out %h value_out %h byte_count %0d last %b",
                       b, v, cnt, lst);
                errors++;
                return;
            end
            r = due.pop_front();
            if (b !== r.enc_byte)
            begin
                $error("byte_out: expected %h, actual %h", r.enc_byte, b);
                errors++;
            end
            if (v !== r.dec_value)
            begin
                $error("value_out: expected %h, actual %h", r.dec_value, v);
                errors++;
            end
            if (cnt !== r.count)
            begin
                $error("byte_count: expected %0d, actual %0d", r.count, cnt);
                errors++;
            end
            if (lst !== r.is_last)
            begin
                $error("last: expected %b, actual %b", r.is_last, lst);
                errors++;
            end
        endfunction
    endclass

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    int        cycles        = 0;
    int        items_sent    = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        hold_req      = 0;
    leb_mirror mirror;

    vc64_in_if  din_if ();
    vc64_out_if dout_if ();

    varint_codec_64 dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_if),
        .dout  (dout_if)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        din_if.valid     = 1'b0;
        din_if.operation = OP_ENCODE;
        din_if.value_in  = '0;
        din_if.byte_in   = '0;
    end

    // Receiver: random stalls, or a long hold-off when requested.
    initial
    begin : receiver
        int hold_left;
        hold_left     = 0;
        dout_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                dout_if.ready = 1'b0;
                hold_left--;
            end
            else
                dout_if.ready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && dout_if.valid && dout_if.ready)
            mirror.check_output(dout_if.byte_out, dout_if.value_out,
                                dout_if.byte_count, dout_if.last);
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [VALUE_W-1:0] rand_value();
        logic [VALUE_W-1:0] v;
        int                 nb;
        v  = {$urandom, $urandom};
        nb = $urandom_range(0, 64);
        // spread over all encoded lengths
        if (nb < 64)
            v &= (64'd1 << nb) - 64'd1;
        return v;
    endfunction

    task automatic send_item(op_t op, logic [VALUE_W-1:0] v, logic [BYTE_W-1:0] b);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            din_if.valid = 1'b0;
            @(negedge clk);
        end
        din_if.operation = op;
        din_if.value_in  = v;
        din_if.byte_in   = b;
        din_if.valid     = 1'b1;
        @(posedge clk);
        while (!din_if.ready)
            @(posedge clk);
        mirror.note_item(op, v, b);
        items_sent++;
    endtask

    task automatic send_encode(logic [VALUE_W-1:0] v);
        send_item(OP_ENCODE, v, 8'($urandom));
    endtask

    task automatic send_decode(logic [BYTE_W-1:0] b);
        send_item(OP_DECODE, {$urandom, $urandom}, b);
    endtask

    // Feeds the LEB128 bytes of v to the decoder, optionally with encodes in between.
    task automatic send_varint(logic [VALUE_W-1:0] v, bit mix);
        logic [VALUE_W-1:0] rest;
        rest = v;
        while (rest >= VALUE_W'(CONT_BIT))
        begin
            send_decode(rest[BYTE_W-1:0] & PAYLOAD_MASK | CONT_BIT);
            rest = rest >> GROUP_W;
            if (mix && $urandom_range(0, 9) == 0)
                send_encode(rand_value());
        end
        send_decode(rest[BYTE_W-1:0]);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        din_if.valid = 1'b0;
        while (mirror.due.size() > 0)
            @(posedge clk);
    endtask

    task automatic run_random(int n);
        int target;
        int pick;
        target = items_sent + n;
        while (items_sent < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                send_encode(rand_value());
            else if (pick < 82)
                send_varint(rand_value(), 1'b1);
            else if (pick < 90)
            begin
                // overlong run: tenth byte ends it whatever its top bit
                repeat (9)
                    send_decode(8'($urandom) | CONT_BIT);
                send_decode(8'($urandom));
            end
            else
                send_decode(8'($urandom));
        end
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, int n);
        @(posedge clk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        run_random(n);
        wait_drained();
    endtask

    initial
    begin : main
        mirror = new();
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: length boundaries and all-ones/top-bit values
        send_encode(64'd0);
        send_encode(64'd1);
        send_encode(64'd127);
        send_encode(64'd128);
        send_encode(64'd16383);
        send_encode(64'h8000_0000_0000_0000);
        send_encode(64'hFFFF_FFFF_FFFF_FFFF);
        send_decode(8'h00);
        send_decode(8'h7F);
        // encode in the middle of a decode leaves the decoder alone
        send_decode(8'h85);
        send_encode(64'd300);
        send_decode(8'h03);
        // ten continuation bytes: forced emit, upper payload bits dropped
        repeat (10)
            send_decode(8'hFF);
        wait_drained();

        run_phase(0, 0, 60);
        run_phase(69, 0, 60);
        run_phase(0, 69, 60);
        run_phase(21, 21, 60);

        // long receiver hold-off while the sender keeps offering
        @(posedge clk);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 200;
        run_random(40);
        wait_drained();

        repeat (10)
            @(posedge clk);
        if (mirror.due.size() != 0)
            mirror.errors++;
        if (mirror.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
